// ----- hdl/fourier_series_waveform_synth_defines.svh -----
// ----------------------------------------------------------------------------
// Fourier series waveform synth - assertion macros
// Shared property templates for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef FOURIER_SERIES_WAVEFORM_SYNTH_DEFINES_SVH
`define FOURIER_SERIES_WAVEFORM_SYNTH_DEFINES_SVH

// Check a consequent in the cycle after the antecedent, no reset gating
`define FSWS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Check a consequent in the same cycle, ignored while reset is high
`define FSWS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/fsws_pkg.sv -----
// ----------------------------------------------------------------------------
// Fourier series waveform synth - package
// Sizes, codes and shared types for the synth, its ROMs and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fsws_pkg;

  // Build sizes
  localparam int MAX_HARMONICS = 256;
  localparam int ANGLE_BITS    = 16;
  localparam int TABLE_BITS    = 10;

  // Port field widths
  localparam int ANGLE_FIELD_W = 16;
  localparam int OUT_W         = 20;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int MODE_W        = 2;
  localparam int HCOUNT_W      = 9;

  // Derived sizes
  localparam int KIDX_W  = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int CNT_W   = $clog2(MAX_HARMONICS + 1);
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int QADDR_W = TABLE_BITS - 1;
  localparam int QVAL_W  = 15;
  localparam int AMP_W   = 16;
  localparam int SINE_W  = 16;
  localparam int PROD_W  = AMP_W + SINE_W;
  localparam int ACC_W   = PROD_W + KIDX_W + 1;
  localparam int FRAC_DROP = 18;

  // Phase to table index alignment
  localparam int PHASE_W = (ANGLE_BITS > TABLE_BITS) ? ANGLE_BITS : TABLE_BITS;
  localparam int IDX_SHR = (ANGLE_BITS >= TABLE_BITS) ? ANGLE_BITS - TABLE_BITS : 0;
  localparam int IDX_SHL = (ANGLE_BITS >= TABLE_BITS) ? 0 : TABLE_BITS - ANGLE_BITS;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Output rails
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Harmonic set codes
  localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HARMONIC_COUNT = 2'd1;

  localparam logic [HCOUNT_W-1:0] HCOUNT_RESET = 9'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } fsws_state_t;

  // ROM request: one harmonic
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [KIDX_W-1:0]     kidx;
    logic [TABLE_BITS-1:0] sin_idx;
    logic [TABLE_BITS-1:0] cos_idx;
  } rom_req_t;

  // ROM read data, registered in the cycle after the request
  typedef struct packed {
    logic signed [AMP_W-1:0]  amp;
    logic signed [SINE_W-1:0] sin_val;
    logic signed [SINE_W-1:0] cos_val;
  } rom_data_t;

endpackage

`default_nettype wire

// ----- hdl/fsws_if.sv -----
// ----------------------------------------------------------------------------
// Fourier series waveform synth - channel interfaces
// Valid/ready channels for angle requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsws_angle_if;
  import fsws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ANGLE_FIELD_W-1:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface fsws_result_if;
  import fsws_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_sum;
  logic signed [OUT_W-1:0] y_sum;
  logic                    saturated;
  modport source (output valid, output x_sum, output y_sum, output saturated, input ready);
  modport sink   (input valid, input x_sum, input y_sum, input saturated, output ready);
endinterface

interface fsws_cfg_if;
  import fsws_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/fsws_rom.sv -----
// ----------------------------------------------------------------------------
// Fourier series waveform synth - coefficient ROMs
// Synchronous amplitude ROM (three harmonic sets, Q8.8) and quarter-wave
// sine ROM (Q1.14) with sine and cosine read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module fsws_rom (
  input  logic                clk,
  input  fsws_pkg::rom_req_t  req,
  output fsws_pkg::rom_data_t data
);
  import fsws_pkg::*;

  logic [QVAL_W-1:0]       quarter_rom [QUARTER+1];
  logic signed [AMP_W-1:0] amp_square  [MAX_HARMONICS];
  logic signed [AMP_W-1:0] amp_saw     [MAX_HARMONICS];
  logic signed [AMP_W-1:0] amp_tri     [MAX_HARMONICS];

  logic [1:0]              sin_quad, cos_quad;
  logic [QADDR_W-1:0]      sin_addr, cos_addr;
  logic signed [SINE_W-1:0] sin_mag, cos_mag;
  logic signed [AMP_W-1:0] amp_sel;
  rom_data_t               data_next;

  // Quarter-wave sine: integer Taylor series through x^11 in Q30
  for (genvar g = 0; g <= QUARTER; g++) begin : gen_sine
    localparam longint unsigned X  = (64'(g) * HALF_PI_Q30) / QUARTER;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X  * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint S  = longint'(X) - longint'(T1) + longint'(T2)
                            - longint'(T3) + longint'(T4) - longint'(T5);
    localparam longint SC = (S < 0) ? 0 : S;
    localparam longint R  = (SC + 32768) / 65536;
    localparam longint RC = (R > 16384) ? 16384 : R;
    assign quarter_rom[g] = QVAL_W'(RC);
  end

  // Amplitudes per harmonic k = g + 1, rounded to Q8.8
  for (genvar g = 0; g < MAX_HARMONICS; g++) begin : gen_amp
    localparam longint unsigned FO = 64'(2 * g + 1);
    localparam longint unsigned FS = 64'(g + 1);
    localparam longint unsigned FF = FO * FO;
    localparam longint SQ = longint'((64'd26075946 + 64'd500 * FO) / (64'd1000 * FO));
    localparam longint SW = 128 - longint'((64'd24446199 + 64'd500 * FS) / (64'd1000 * FS));
    localparam longint TM = longint'((64'd20750578 + 64'd500 * FF) / (64'd1000 * FF));
    localparam longint TR = (g % 2 == 0) ? TM : -TM;
    assign amp_square[g] = AMP_W'(SQ);
    assign amp_saw[g]    = AMP_W'(SW);
    assign amp_tri[g]    = AMP_W'(TR);
  end

  // Fold table index into the first quadrant
  always_comb begin
    sin_quad = req.sin_idx[TABLE_BITS-1 -: 2];
    cos_quad = req.cos_idx[TABLE_BITS-1 -: 2];
    sin_addr = sin_quad[0]
             ? QADDR_W'(QUARTER) - {1'b0, req.sin_idx[TABLE_BITS-3:0]}
             : {1'b0, req.sin_idx[TABLE_BITS-3:0]};
    cos_addr = cos_quad[0]
             ? QADDR_W'(QUARTER) - {1'b0, req.cos_idx[TABLE_BITS-3:0]}
             : {1'b0, req.cos_idx[TABLE_BITS-3:0]};
    sin_mag  = $signed({1'b0, quarter_rom[sin_addr]});
    cos_mag  = $signed({1'b0, quarter_rom[cos_addr]});
    case (req.mode)
      MODE_SQUARE:   amp_sel = amp_square[req.kidx];
      MODE_SAWTOOTH: amp_sel = amp_saw[req.kidx];
      MODE_TRIANGLE: amp_sel = amp_tri[req.kidx];
      default:       amp_sel = '0;
    endcase
    data_next.amp     = amp_sel;
    data_next.sin_val = sin_quad[1] ? -sin_mag : sin_mag;
    data_next.cos_val = cos_quad[1] ? -cos_mag : cos_mag;
  end

  // Register the read data
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ----- hdl/fourier_series_waveform_synth.sv -----
// ----------------------------------------------------------------------------
// Fourier series waveform synth - top level
// Additive square, sawtooth and triangle synthesis: sums r_k*cos and r_k*sin
// over the selected harmonics for each angle, rounds and saturates.
// ----------------------------------------------------------------------------
//
//  channel | role   | payload                          | request moves
//  --------+--------+----------------------------------+------------------------
//  sample  | sink   | angle[15:0]                      | one angle per request
//  result  | source | x_sum[19:0], y_sum[19:0], sat.   | one result per angle
//  cfg     | sink   | index[1:0], data[8:0]            | one register write
//
//  Each accepted angle runs N harmonics through the ROM, multiply and
//  accumulate stages, where N = min(harmonic_count, 256), or 0 for the
//  unused mode code; the pipeline takes one harmonic per cycle. One angle
//  is in work at a time; a new one is taken while the previous result waits
//  in the output register. Reset is synchronous and clears the control
//  state and the registers (square set, 16 harmonics). A stalled result
//  holds the finish step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fourier_series_waveform_synth (
  input  logic          clk,
  input  logic          rst,
  fsws_angle_if.sink    sample,
  fsws_cfg_if.sink      cfg,
  fsws_result_if.source result
);
  import fsws_pkg::*;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_DROP - 1);
  localparam logic [ACC_W-1:0] POS_LIMIT  = ACC_W'(OUT_MAX);
  localparam logic [ACC_W-1:0] NEG_LIMIT  = ACC_W'(1) << (OUT_W - 1);

  fsws_state_t state, state_next;

  logic [MODE_W-1:0]   wave_mode;
  logic [HCOUNT_W-1:0] harmonic_count;

  logic [ANGLE_BITS-1:0] angle_in;
  logic [ANGLE_BITS-1:0] phase;
  logic [ANGLE_BITS-1:0] step;
  logic [KIDX_W-1:0]     kidx;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      eff_count;
  logic [PHASE_W-1:0]    phase_w;

  logic start, issue, load_out;
  logic v1, v2;

  rom_req_t  rom_req;
  rom_data_t rom_data;

  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic [OUT_W:0]           fin_x, fin_y;

  logic                    out_valid;
  logic signed [OUT_W-1:0] out_x, out_y;
  logic                    out_sat;

  // Round half away from zero, drop fraction bits, clip to the output range
  function automatic logic [OUT_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        rnd;
    logic                    clip;
    logic signed [OUT_W-1:0] v;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rnd = (mag + ROUND_HALF) >> FRAC_DROP;
    if (!acc[ACC_W-1]) begin
      clip = (rnd > POS_LIMIT);
      v    = clip ? OUT_MAX : OUT_W'(rnd);
    end else begin
      clip = (rnd > NEG_LIMIT);
      v    = clip ? OUT_MIN : OUT_W'(ACC_W'(0) - rnd);
    end
    return {clip, v};
  endfunction

  // Register writes: always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode      <= MODE_SQUARE;
      harmonic_count <= HCOUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WAVE_MODE:      wave_mode      <= cfg.data[MODE_W-1:0];
        CFG_HARMONIC_COUNT: harmonic_count <= cfg.data[HCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Number of harmonics for this angle
  always_comb begin
    if (wave_mode != MODE_SQUARE && wave_mode != MODE_SAWTOOTH &&
        wave_mode != MODE_TRIANGLE) begin
      eff_count = '0;
    end else if (32'(harmonic_count) > MAX_HARMONICS) begin
      eff_count = CNT_W'(MAX_HARMONICS);
    end else begin
      eff_count = CNT_W'(harmonic_count);
    end
  end

  assign angle_in = ANGLE_BITS'(sample.angle);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          start      = 1'b1;
          state_next = (eff_count == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (cnt == CNT_W'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !v2) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign sample.ready = (state == ST_IDLE);

  // Advance harmonic index, phase and remaining count
  always_ff @(posedge clk) begin
    if (start) begin
      phase <= angle_in;
      step  <= (wave_mode == MODE_SAWTOOTH) ? angle_in : ANGLE_BITS'(angle_in << 1);
      kidx  <= '0;
      cnt   <= eff_count;
    end else if (issue) begin
      phase <= phase + step;
      kidx  <= kidx + KIDX_W'(1);
      cnt   <= cnt - CNT_W'(1);
    end
  end

  // ROM addresses from the current phase
  always_comb begin
    phase_w         = PHASE_W'(phase);
    rom_req.mode    = wave_mode;
    rom_req.kidx    = kidx;
    rom_req.sin_idx = TABLE_BITS'((phase_w >> IDX_SHR) << IDX_SHL);
    rom_req.cos_idx = rom_req.sin_idx + TABLE_BITS'(QUARTER);
  end

  fsws_rom u_rom (
    .clk  (clk),
    .req  (rom_req),
    .data (rom_data)
  );

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // Multiply amplitude by cosine and sine
  always_ff @(posedge clk) begin
    prod_x <= $signed(rom_data.amp) * $signed(rom_data.cos_val);
    prod_y <= $signed(rom_data.amp) * $signed(rom_data.sin_val);
  end

  // Accumulate the products
  always_ff @(posedge clk) begin
    if (start) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (v2) begin
      acc_x <= acc_x + ACC_W'(prod_x);
      acc_y <= acc_y + ACC_W'(prod_y);
    end
  end

  assign fin_x = round_sat(acc_x);
  assign fin_y = round_sat(acc_y);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x   <= fin_x[OUT_W-1:0];
      out_y   <= fin_y[OUT_W-1:0];
      out_sat <= fin_x[OUT_W] | fin_y[OUT_W];
    end
  end

  assign result.valid     = out_valid;
  assign result.x_sum     = out_x;
  assign result.y_sum     = out_y;
  assign result.saturated = out_sat;

endmodule

`default_nettype wire

// ----- hdl/fsws_checker.sv -----
// ----------------------------------------------------------------------------
// Fourier series waveform synth - port checker
// Watches the top-level channels over time; attached by a bind below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fourier_series_waveform_synth_defines.svh"

module fsws_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [fsws_pkg::OUT_W-1:0] x_sum,
  input logic signed [fsws_pkg::OUT_W-1:0] y_sum,
  input logic                           saturated
);
  import fsws_pkg::*;

  // No result straight out of reset
  `FSWS_ASSERT_NEXT(a_no_result_after_reset, clk, rst, !out_valid, "result valid after reset")

  // One angle in work at a time
  `FSWS_ASSERT_NEXT(a_one_in_work, clk, !rst && in_valid && in_ready, !in_ready, "second angle taken while busy")

  // A clipped result sits on a rail
  `FSWS_ASSERT_NOW(a_sat_on_rail, clk, rst, out_valid && saturated, x_sum == OUT_MAX || x_sum == OUT_MIN || y_sum == OUT_MAX || y_sum == OUT_MIN, "saturated flag without a clipped sum")

  // A stalled result holds
  `FSWS_ASSERT_NEXT(a_hold_stalled, clk, !rst && out_valid && !out_ready, out_valid && $stable(x_sum) && $stable(y_sum) && $stable(saturated), "stalled result changed")

  // Finishing a result frees the input side
  `FSWS_ASSERT_NOW(a_result_frees_input, clk, rst, $rose(out_valid), in_ready, "input not free after result")

endmodule

bind fourier_series_waveform_synth fsws_checker u_fsws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .x_sum     (result.x_sum),
  .y_sum     (result.y_sum),
  .saturated (result.saturated)
);

`default_nettype wire
